// ----- rtl/table_quadratic_float_function_unit_assert.svh -----
// Assertion macros for the function unit RTL, used by tqf_queue.
// Each expects signals clk and rst_n in the including module's scope.
`ifndef TABLE_QUADRATIC_FLOAT_FUNCTION_UNIT_ASSERT_SVH
`define TABLE_QUADRATIC_FLOAT_FUNCTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TQF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tqf check failed");

// Next-cycle implication, disabled during reset
`define TQF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tqf check failed");

`endif

// ----- rtl/tqf_pkg.sv -----
// Shared types and constants for the table quadratic float function unit.
// No dependencies.
package tqf_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int OFF_W         = 17;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_NOT_POS = 2'd2;

  localparam logic [2:0] REG_ARG_MIN   = 3'd0;
  localparam logic [2:0] REG_ARG_MAX   = 3'd1;
  localparam logic [2:0] REG_EXP_MIN   = 3'd2;
  localparam logic [2:0] REG_EXP_MAX   = 3'd3;
  localparam logic [2:0] REG_SMALL_RES = 3'd4;

  // Bounds used by the front classifier
  typedef struct packed {
    logic [30:0] arg_min;
    logic [30:0] arg_max;
    logic [7:0]  exp_min;
    logic [7:0]  exp_max;
  } cfg_t;

  // Classified transaction held in the queue
  typedef struct packed {
    logic             load;
    logic             reject;
    logic             small_hit;
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    logic [30:0]      c0;
    logic [27:0]      c1;
    logic [27:0]      c2;
  } item_t;

endpackage

// ----- rtl/tqf_front.sv -----
// Front end: checks the argument, aligns the mantissa, forms index and offset.
// Depends on tqf_pkg.
module tqf_front (
  input  tqf_pkg::cfg_t  cfg,
  input  logic           opcode,
  input  logic [31:0]    arg_bits,
  input  logic [6:0]     entry_index,
  input  logic [30:0]    coef_zero,
  input  logic [27:0]    coef_one,
  input  logic [27:0]    coef_two,
  output tqf_pkg::item_t item
);

  logic [7:0]  e;
  logic [30:0] mag;
  logic [7:0]  sh;
  logic [23:0] mant;
  logic [23:0] m;
  logic        bad;

  assign e    = arg_bits[30:23];
  assign mag  = arg_bits[30:0];
  assign mant = {1'b1, arg_bits[22:0]};
  assign sh   = 8'd126 - e;

  // Range and class checks
  assign bad = arg_bits[31] || (e == 8'd0) || (e == 8'hFF) ||
               (cfg.arg_min > 31'h7F800000) || (cfg.arg_max > 31'h7F800000) ||
               (mag < cfg.arg_min) || (mag > cfg.arg_max) ||
               (e < cfg.exp_min) || (e > cfg.exp_max) || (e > 8'd127);

  // Alignment; only bits 23..0 of the aligned value matter
  always_comb begin
    if (e == 8'd127) begin
      m = {arg_bits[22:0], 1'b0};
    end else if (sh > 8'd23) begin
      m = '0;
    end else begin
      m = mant >> sh[4:0];
    end
  end

  always_comb begin
    item.load      = (opcode == tqf_pkg::OP_LOAD);
    item.reject    = bad;
    item.off       = m[16:0];
    item.small_hit = (m[23:0] == 24'd0);
    item.idx       = item.load ? entry_index : m[23:17];
    item.c0        = coef_zero;
    item.c1        = coef_one;
    item.c2        = coef_two;
  end

endmodule

// ----- rtl/tqf_queue.sv -----
// Small FIFO between the front and back ends.
// Depends on tqf_pkg and the assertion macro header.
`include "table_quadratic_float_function_unit_assert.svh"
module tqf_queue #(
  parameter int DEPTH = tqf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tqf_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tqf_pkg::item_t rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tqf_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rp_r];

  // Pointer and count update
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  `TQF_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `TQF_ASSERT_NOW(a_no_pop_empty, pop, !empty)
  `TQF_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

// ----- rtl/tqf_back.sv -----
// Back end: coefficient tables, products, sum, normalization and result register.
// Depends on tqf_pkg.
module tqf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  tqf_pkg::item_t q_item,
  output logic           q_pop,
  input  logic [31:0]    small_bits,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_result_bits,
  output logic           out_inexact,
  output logic [1:0]     out_status
);

  logic en;

  logic [30:0] c0_tab [tqf_pkg::TABLE_ENTRIES];
  logic [27:0] c1_tab [tqf_pkg::TABLE_ENTRIES];
  logic [27:0] c2_tab [tqf_pkg::TABLE_ENTRIES];

  // Stage 1: table read
  logic        v1_r, rj1_r, sm1_r;
  logic [16:0] off1_r;
  logic [30:0] c0_1_r;
  logic [27:0] c1_1_r, c2_1_r;
  // Stage 2: first products
  logic        v2_r, rj2_r, sm2_r;
  logic [30:0] c0_2_r;
  logic [27:0] c2_2_r;
  logic signed [45:0] p1_2_r;
  logic [33:0] sq_2_r;
  // Stage 3: quadratic term
  logic        v3_r, rj3_r, sm3_r;
  logic [30:0] c0_3_r;
  logic signed [45:0] p1_3_r;
  logic signed [62:0] p2_3_r;
  // Stage 4: sum
  logic        v4_r, rj4_r, sm4_r, pos4_r;
  logic [63:0] sum4_r;
  logic signed [65:0] tot;
  // Stage 5: leading zero count
  logic        v5_r, rj5_r, sm5_r, pos5_r;
  logic [63:0] sum5_r;
  logic [5:0]  nlz5_r;
  logic [5:0]  nlz;
  logic        found;
  // Output register
  logic        ov_r;
  logic [31:0] res_r;
  logic        inx_r;
  logic [1:0]  st_r;
  logic [63:0] norm;

  assign en    = !ov_r || out_ready;
  assign q_pop = en && !q_empty;

  // Coefficient tables
  always_ff @(posedge clk) begin
    if (q_pop && q_item.load) begin
      c0_tab[q_item.idx] <= q_item.c0;
      c1_tab[q_item.idx] <= q_item.c1;
      c2_tab[q_item.idx] <= q_item.c2;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_pop && !q_item.load;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      ov_r <= v5_r;
    end
  end

  // Total in 66 bits: c0*2^32 + c1*x*2^18 + c2*x*x
  assign tot = $signed({3'b000, c0_3_r, 32'd0}) +
               ($signed({{2{p1_3_r[45]}}, p1_3_r, 18'd0})) +
               $signed({{3{p2_3_r[62]}}, p2_3_r});

  // Leading zero count of the positive sum
  always_comb begin
    nlz   = '0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && sum4_r[i]) begin
        nlz   = 6'(63 - i);
        found = 1'b1;
      end
    end
  end

  assign norm = sum5_r << nlz5_r;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      if (q_pop) begin
        c0_1_r <= c0_tab[q_item.idx];
        c1_1_r <= c1_tab[q_item.idx];
        c2_1_r <= c2_tab[q_item.idx];
      end
      rj1_r  <= q_item.reject;
      sm1_r  <= q_item.small_hit;
      off1_r <= q_item.off;

      rj2_r  <= rj1_r;
      sm2_r  <= sm1_r;
      c0_2_r <= c0_1_r;
      c2_2_r <= c2_1_r;
      p1_2_r <= $signed(c1_1_r) * $signed({1'b0, off1_r});
      sq_2_r <= off1_r * off1_r;

      rj3_r  <= rj2_r;
      sm3_r  <= sm2_r;
      c0_3_r <= c0_2_r;
      p1_3_r <= p1_2_r;
      p2_3_r <= $signed(c2_2_r) * $signed({1'b0, sq_2_r});

      rj4_r  <= rj3_r;
      sm4_r  <= sm3_r;
      pos4_r <= !tot[65] && (tot != '0);
      sum4_r <= tot[63:0];

      rj5_r  <= rj4_r;
      sm5_r  <= sm4_r;
      pos5_r <= pos4_r;
      sum5_r <= sum4_r;
      nlz5_r <= nlz;

      // Result selection
      if (rj5_r) begin
        res_r <= '0;
        inx_r <= 1'b0;
        st_r  <= tqf_pkg::ST_BAD_ARG;
      end else if (sm5_r) begin
        res_r <= small_bits;
        inx_r <= 1'b1;
        st_r  <= tqf_pkg::ST_OK;
      end else if (!pos5_r) begin
        res_r <= '0;
        inx_r <= 1'b0;
        st_r  <= tqf_pkg::ST_NOT_POS;
      end else begin
        res_r <= {1'b0, 8'd132 - {2'b00, nlz5_r}, norm[62:40]};
        inx_r <= (norm[39:0] != '0);
        st_r  <= tqf_pkg::ST_OK;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_result_bits = res_r;
  assign out_inexact     = inx_r;
  assign out_status      = st_r;

endmodule

// ----- rtl/table_quadratic_float_function_unit.sv -----
// Top level of the table quadratic float function unit: config registers and wiring.
// Depends on tqf_pkg, tqf_front, tqf_queue and tqf_back.
//
// Channel   Direction  Handshake           Carries
// in_       input      in_valid/in_ready   opcode, argument, table entry load
// out_      output     out_valid/out_ready result bits, inexact, status
// cfg       input      APB psel/penable    five bound and value registers
//
// One transaction per cycle is accepted while the queue has room; loads give no result.
// An evaluate result passes through the queue and then the six-stage back end
// (table read, two multiplier stages, sum, leading zero count, output register).
// Reset clears the queue and stage valids; tables are undefined until loaded.
// An output stall freezes the back end; the front keeps accepting until the queue fills.
module table_quadratic_float_function_unit #(
  parameter int QUEUE_DEPTH = tqf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_arg_bits,
  input  logic [6:0]  in_entry_index,
  input  logic [30:0] in_coef_zero,
  input  logic [27:0] in_coef_one,
  input  logic [27:0] in_coef_two,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits,
  output logic        out_inexact,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0] arg_min_r, arg_max_r;
  logic [7:0]  exp_min_r, exp_max_r;
  logic [31:0] small_r;
  logic        wr_en;
  tqf_pkg::cfg_t  cfg;
  tqf_pkg::item_t f_item, q_item;
  logic q_full, q_empty, q_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_min_r <= 31'd0;
      arg_max_r <= 31'h7F7FFFFF;
      exp_min_r <= 8'd1;
      exp_max_r <= 8'd127;
      small_r   <= 32'd0;
    end else if (wr_en) begin
      case (paddr[4:2])
        tqf_pkg::REG_ARG_MIN:   arg_min_r <= pwdata[30:0];
        tqf_pkg::REG_ARG_MAX:   arg_max_r <= pwdata[30:0];
        tqf_pkg::REG_EXP_MIN:   exp_min_r <= pwdata[7:0];
        tqf_pkg::REG_EXP_MAX:   exp_max_r <= pwdata[7:0];
        tqf_pkg::REG_SMALL_RES: small_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      tqf_pkg::REG_ARG_MIN:   prdata = {1'b0, arg_min_r};
      tqf_pkg::REG_ARG_MAX:   prdata = {1'b0, arg_max_r};
      tqf_pkg::REG_EXP_MIN:   prdata = {24'd0, exp_min_r};
      tqf_pkg::REG_EXP_MAX:   prdata = {24'd0, exp_max_r};
      tqf_pkg::REG_SMALL_RES: prdata = small_r;
      default:                prdata = '0;
    endcase
  end

  assign cfg.arg_min = arg_min_r;
  assign cfg.arg_max = arg_max_r;
  assign cfg.exp_min = exp_min_r;
  assign cfg.exp_max = exp_max_r;

  assign in_ready = !q_full;

  tqf_front u_front (
    .cfg         (cfg),
    .opcode      (in_opcode),
    .arg_bits    (in_arg_bits),
    .entry_index (in_entry_index),
    .coef_zero   (in_coef_zero),
    .coef_one    (in_coef_one),
    .coef_two    (in_coef_two),
    .item        (f_item)
  );

  tqf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_valid && in_ready),
    .wr_item (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  tqf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .small_bits      (small_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_bits (out_result_bits),
    .out_inexact     (out_inexact),
    .out_status      (out_status)
  );

endmodule

// ----- tb/table_quadratic_float_function_unit_test.sv -----
// Self-checking testbench for table_quadratic_float_function_unit.
// Depends on tqf_pkg and the unit RTL; predicts each evaluate result and checks it.
`timescale 1ns / 1ps

module table_quadratic_float_function_unit_test;

  typedef struct {
    logic [31:0] bits;
    logic        inex;
    logic [1:0]  st;
  } fresult_t;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = tqf_pkg::OP_EVAL;
  logic [31:0] in_arg_bits = '0;
  logic [6:0]  in_entry_index = '0;
  logic [30:0] in_coef_zero = '0;
  logic [27:0] in_coef_one = '0;
  logic [27:0] in_coef_two = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [31:0] out_result_bits;
  logic        out_inexact;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of tables and bounds
  logic [30:0] c0_tab [tqf_pkg::TABLE_ENTRIES];
  logic [27:0] c1_tab [tqf_pkg::TABLE_ENTRIES];
  logic [27:0] c2_tab [tqf_pkg::TABLE_ENTRIES];
  logic [30:0] arg_lo = 31'd0;
  logic [30:0] arg_hi = 31'h7F7FFFFF;
  logic [7:0]  exp_lo = 8'd1;
  logic [7:0]  exp_hi = 8'd127;
  logic [31:0] small_val = 32'd0;

  fresult_t pending_results[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  table_quadratic_float_function_unit uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    fresult_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result bits=%h inexact=%b status=%0d", $time,
                 out_result_bits, out_inexact, out_status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (out_result_bits !== exp_r.bits) begin
          $display("%0t: result_bits expected %h actual %h", $time, exp_r.bits,
                   out_result_bits);
          errors++;
        end
        if (out_inexact !== exp_r.inex) begin
          $display("%0t: inexact expected %b actual %b", $time, exp_r.inex, out_inexact);
          errors++;
        end
        if (out_status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, out_status);
          errors++;
        end
      end
    end
  end

  // Evaluate one argument against the current tables and bounds
  function automatic fresult_t eval_arg(logic [31:0] arg);
    fresult_t r;
    logic [7:0]  e;
    logic [30:0] mag;
    logic [24:0] m;
    logic [6:0]  ix;
    logic [16:0] off;
    logic [63:0] a0, c1x, c2x, offx, s, sum, mag_s;
    int nlz;
    r.bits = '0;
    r.inex = 1'b0;
    r.st = tqf_pkg::ST_OK;
    e = arg[30:23];
    mag = arg[30:0];
    if (arg[31] || e == 8'd0 || e == 8'hFF || arg_lo > 31'h7F800000 ||
        arg_hi > 31'h7F800000 || mag < arg_lo || mag > arg_hi ||
        e < exp_lo || e > exp_hi || e > 8'd127) begin
      r.st = tqf_pkg::ST_BAD_ARG;
      return r;
    end
    m = {2'b01, arg[22:0]};
    if (e == 8'd127) m = m << 1;
    else if (126 - int'(e) > 23) m = '0;
    else m = m >> (126 - int'(e));
    off = m[16:0];
    ix = m[23:17];
    if (ix == 0 && off == 0) begin
      r.bits = small_val;
      r.inex = 1'b1;
      return r;
    end
    a0 = {1'b0, c0_tab[ix], 32'd0};
    c1x = {{36{c1_tab[ix][27]}}, c1_tab[ix]};
    c2x = {{36{c2_tab[ix][27]}}, c2_tab[ix]};
    offx = {47'd0, off};
    s = ((c1x * offx) << 18) + c2x * (offx * offx);
    if (!s[63]) begin
      sum = a0 + s;
    end else begin
      mag_s = -s;
      if (a0 <= mag_s) begin
        r.st = tqf_pkg::ST_NOT_POS;
        return r;
      end
      sum = a0 - mag_s;
    end
    if (sum == 0) begin
      r.st = tqf_pkg::ST_NOT_POS;
      return r;
    end
    nlz = 0;
    while (!sum[63]) begin
      sum = sum << 1;
      nlz++;
    end
    r.bits = {1'b0, 8'(132 - nlz), sum[62:40]};
    r.inex = |sum[39:0];
    return r;
  endfunction

  // Send one transaction; once accepted, update the predictor tables or record its prediction
  task automatic send_item(logic op, logic [31:0] arg, logic [6:0] ix,
                           logic [30:0] c0, logic [27:0] c1, logic [27:0] c2);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_arg_bits <= arg;
    in_entry_index <= ix;
    in_coef_zero <= c0;
    in_coef_one <= c1;
    in_coef_two <= c2;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (op == tqf_pkg::OP_LOAD) begin
      c0_tab[ix] = c0;
      c1_tab[ix] = c1;
      c2_tab[ix] = c2;
    end else begin
      pending_results.push_back(eval_arg(arg));
    end
  endtask

  task automatic eval_item(logic [31:0] arg);
    send_item(tqf_pkg::OP_EVAL, arg, 7'($urandom), 31'($urandom), 28'($urandom),
              28'($urandom));
  endtask

  task automatic load_item(logic [6:0] ix, logic [30:0] c0, logic [27:0] c1,
                           logic [27:0] c2);
    send_item(tqf_pkg::OP_LOAD, $urandom, ix, c0, c1, c2);
  endtask

  // Drain outstanding results, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // APB write: setup then access
  task automatic write_reg(logic [2:0] r, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      tqf_pkg::REG_ARG_MIN:   arg_lo = v[30:0];
      tqf_pkg::REG_ARG_MAX:   arg_hi = v[30:0];
      tqf_pkg::REG_EXP_MIN:   exp_lo = v[7:0];
      tqf_pkg::REG_EXP_MAX:   exp_hi = v[7:0];
      tqf_pkg::REG_SMALL_RES: small_val = v;
      default: ;
    endcase
  endtask

  task automatic set_bounds(logic [31:0] lo, logic [31:0] hi, logic [7:0] elo,
                            logic [7:0] ehi, logic [31:0] sv);
    write_reg(tqf_pkg::REG_ARG_MIN, lo);
    write_reg(tqf_pkg::REG_ARG_MAX, hi);
    write_reg(tqf_pkg::REG_EXP_MIN, {24'd0, elo});
    write_reg(tqf_pkg::REG_EXP_MAX, {24'd0, ehi});
    write_reg(tqf_pkg::REG_SMALL_RES, sv);
  endtask

  // Mostly in-range positive normals, some raw noise
  function automatic logic [31:0] random_arg();
    if ($urandom_range(0, 6) == 0) return $urandom;
    return {1'b0, 8'($urandom_range(100, 127)), 23'($urandom)};
  endfunction

  // Every table entry gets defined contents before any evaluate
  task automatic test_table_fill();
    for (int i = 0; i < tqf_pkg::TABLE_ENTRIES; i++)
      load_item(7'(i), 31'($urandom), 28'($urandom), 28'($urandom));
  endtask

  task automatic test_directed();
    load_item(7'h40, 31'd0, 28'h8000000, 28'h0000001);       // drives sum negative
    load_item(7'h7F, 31'h7FFFFFFF, 28'h7FFFFFF, 28'h7FFFFFF); // largest sum
    load_item(7'h41, 31'd1, 28'd0, 28'd0);                  // tiny positive sum
    eval_item(32'h3F000000);   // 0.5 hits entry 0x40 with zero offset
    eval_item(32'h3F010000);   // entry 0x40, nonzero offset, negative sum
    eval_item(32'h3F7FFFFF);   // entry 0x7F, full offset
    eval_item(32'h3F020000);   // entry 0x41
    eval_item(32'h3F800000);   // 1.0: index and offset both zero
    eval_item(32'h3FFFFFFF);   // exponent 127, max mantissa
    eval_item(32'h33800000);   // shift of 23
    eval_item(32'h33000000);   // shift beyond 23: tiny argument
    eval_item(32'h00800000);   // smallest normal
    eval_item(32'h00000000);   // zero
    eval_item(32'h007FFFFF);   // denormal
    eval_item(32'hBF000000);   // negative
    eval_item(32'h7F800000);   // infinity
    eval_item(32'h7FC00000);   // NaN
    eval_item(32'h40000000);   // exponent above 127
    eval_item(32'hFFFFFFFF);
    drain();
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0)
        load_item(7'($urandom), 31'($urandom), 28'($urandom), 28'($urandom));
      else
        eval_item(random_arg());
    end
    drain();
  endtask

  task automatic test_config_sweep();
    set_bounds(32'h3F000000, 32'h3F7FFFFF, 8'd120, 8'd126, $urandom);
    random_phase(300);
    set_bounds(32'h0, 32'h7F800000, 8'd0, 8'd255, 32'hFFFFFFFF);
    random_phase(300);
    set_bounds(32'h7F800001, 32'h7FFFFFFF, 8'd0, 8'd255, $urandom);
    random_phase(40);
    set_bounds(32'h7FFFFFFF, 32'h0, 8'd255, 8'd0, 32'h0);
    random_phase(40);
    set_bounds(32'h30000000, 32'h3FFFFFFF, 8'd96, 8'd127, $urandom);
    random_phase(500);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    set_bounds(32'h0, 32'h7F7FFFFF, 8'd1, 8'd127, $urandom);
    random_phase(470);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed();
    random_phase(150);
    test_config_sweep();
    test_full_rate();
    $display("Sent %0d transactions, checked %0d results across bound settings",
             sent, checked);
    $display("including reject, tiny, small-value and non-positive cases");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
